### src/fce_pkg.sv
// ----------------------------------------------------------------------------
// fce_pkg
// shared codes, types and link encode/decode helpers for the fat chain engine
// ----------------------------------------------------------------------------
package fce_pkg;

    // table formats
    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;

    // actions
    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_SET   = 3'd1;
    localparam logic [2:0] ACT_FIND  = 3'd2;
    localparam logic [2:0] ACT_FREE  = 3'd3;
    localparam logic [2:0] ACT_END   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_BROKEN = 2'd2;
    localparam logic [1:0] ST_NOFREE = 2'd3;

    // configuration register indexes
    localparam logic CFG_FAT_KIND      = 1'b0;
    localparam logic CFG_CLUSTER_COUNT = 1'b1;

    localparam logic [1:0]  KIND_RESET  = KIND_FAT32;
    localparam logic [13:0] COUNT_RESET = 14'd16382;
    localparam logic [13:0] HINT_RESET  = 14'd2;

    // memory command
    typedef struct packed {
        logic rd;
        logic wr;
    } fce_mem_cmd_t;

    function automatic logic [27:0] end_value(input logic [1:0] kind);
        logic [27:0] ev;
        if (kind == KIND_FAT12)
            ev = 28'h0000FF8;
        else if (kind == KIND_FAT16)
            ev = 28'h000FFF8;
        else
            ev = 28'hFFFFFF8;
        return ev;
    endfunction

    // bytes per entry access
    function automatic logic [2:0] link_bytes(input logic [1:0] kind);
        logic [2:0] nb;
        if (kind == KIND_FAT12 || kind == KIND_FAT16)
            nb = 3'd2;
        else
            nb = 3'd4;
        return nb;
    endfunction

    // raw little-endian bytes to link value
    function automatic logic [27:0] decode_link(input logic [1:0] kind, input logic odd,
                                                input logic [31:0] raw);
        logic [27:0] v;
        if (kind == KIND_FAT12)
            v = odd ? {16'd0, raw[15:4]} : {16'd0, raw[11:0]};
        else if (kind == KIND_FAT16)
            v = {12'd0, raw[15:0]};
        else
            v = raw[27:0];
        if (v > end_value(kind))
            v = {v[27:4], 4'd0};
        return v;
    endfunction

    // link value to bytes, fat12 keeps the neighbor nibble
    function automatic logic [31:0] encode_link(input logic [1:0] kind, input logic odd,
                                                input logic [27:0] v, input logic [31:0] raw);
        logic [31:0] w;
        if (kind == KIND_FAT12)
            w = odd ? {16'd0, v[11:0], raw[3:0]} : {16'd0, raw[15:12], v[11:0]};
        else if (kind == KIND_FAT16)
            w = {16'd0, v[15:0]};
        else
            w = {4'd0, v};
        return w;
    endfunction

endpackage

### src/fce_if.sv
// ----------------------------------------------------------------------------
// fce channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface fce_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [13:0] cluster;
    logic [27:0] link_value;

    modport source (output valid, output action, output cluster, output link_value,
                    input ready);
    modport sink   (input valid, input action, input cluster, input link_value,
                    output ready);
endinterface

interface fce_out_if;
    logic        valid;
    logic        ready;
    logic [27:0] result_value;
    logic [1:0]  status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

### src/fce_store.sv
// ----------------------------------------------------------------------------
// fce_store
// byte-wide table memory with registered read and a clearing pass after reset
// ----------------------------------------------------------------------------
module fce_store #(
    parameter int AW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fce_pkg::fce_mem_cmd_t cmd,
    input  logic [AW-1:0]         addr,
    input  logic [7:0]            wdata,
    output logic [7:0]            rdata,
    output logic                  busy
);

    logic [7:0]    mem [2**AW];
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic [7:0]    rdata_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg + AW'(1);
        busy_next    = busy_reg && (clr_cnt_reg != '1);
        wr_en        = busy_reg || cmd.wr;
        wr_addr      = busy_reg ? clr_cnt_reg : addr;
        wr_data      = busy_reg ? 8'd0 : wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

### src/fce_seq.sv
// ----------------------------------------------------------------------------
// fce_seq
// operation sequencer: byte reads, link decode, read-modify-write, scans, walks
// ----------------------------------------------------------------------------
module fce_seq #(
    parameter int MAX_CLUSTERS = 16384,
    parameter int AW           = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fce_in_if.sink                in_ch,
    fce_out_if.source             out_ch,
    input  logic [1:0]            fat_kind,
    input  logic [13:0]           cluster_count,
    input  logic                  store_busy,
    output fce_pkg::fce_mem_cmd_t mem_cmd,
    output logic [AW-1:0]         mem_addr,
    output logic [7:0]            mem_wdata,
    input  logic [7:0]            mem_rdata
);

    localparam int CW = $clog2(MAX_CLUSTERS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_POST  = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_AFTER = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]  state_reg,   state_next;
    logic [2:0]  act_reg,     act_next;
    logic [27:0] cl_reg,      cl_next;
    logic [27:0] lv_reg,      lv_next;
    logic [27:0] nx_reg,      nx_next;
    logic [27:0] wval_reg,    wval_next;
    logic [27:0] res_reg,     res_next;
    logic [1:0]  st_reg,      st_next;
    logic [13:0] steps_reg,   steps_next;
    logic [13:0] hint_reg,    hint_next;
    logic [31:0] raw_reg,     raw_next;
    logic [2:0]  cnt_reg,     cnt_next;
    logic        pend_reg,    pend_next;
    logic [1:0]  lane_reg,    lane_next;
    logic        phase_reg,   phase_next;
    logic        ovalid_reg,  ovalid_next;
    logic [27:0] ores_reg,    ores_next;
    logic [1:0]  ost_reg,     ost_next;

    logic [27:0]   end_v;
    logic [2:0]    nb;
    logic [27:0]   link;
    logic [31:0]   wbytes;
    logic [14:0]   count_p1;
    logic          cl_rng;
    logic          hint_rng;
    logic [AW-1:0] c_ext;
    logic [AW-1:0] base;
    logic          accept;

    function automatic logic in_rng(input logic [27:0] c, input logic [1:0] kind,
                                    input logic [14:0] cp1);
        logic ok;
        ok = (c >= 28'd2) && (c <= {13'd0, cp1}) && ({4'd0, c} < 32'(MAX_CLUSTERS));
        if (kind == fce_pkg::KIND_FAT12 && c >= 28'h0000FF8)
            ok = 1'b0;
        if (kind == fce_pkg::KIND_FAT16 && c >= 28'h000FFF8)
            ok = 1'b0;
        return ok;
    endfunction

    always_comb
    begin
        end_v    = fce_pkg::end_value(fat_kind);
        nb       = fce_pkg::link_bytes(fat_kind);
        link     = fce_pkg::decode_link(fat_kind, cl_reg[0], raw_reg);
        wbytes   = fce_pkg::encode_link(fat_kind, cl_reg[0], wval_reg, raw_reg);
        count_p1 = {1'b0, cluster_count} + 15'd1;
        cl_rng   = in_rng(cl_reg, fat_kind, count_p1);
        hint_rng = in_rng({14'd0, hint_reg}, fat_kind, count_p1);
        c_ext    = AW'(cl_reg[CW-1:0]);
        if (fat_kind == fce_pkg::KIND_FAT12)
            base = (c_ext + (c_ext << 1)) >> 1;
        else if (fat_kind == fce_pkg::KIND_FAT16)
            base = c_ext << 1;
        else
            base = c_ext << 2;
    end

    assign in_ch.ready = (state_reg == S_IDLE) && !store_busy;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        cl_next     = cl_reg;
        lv_next     = lv_reg;
        nx_next     = nx_reg;
        wval_next   = wval_reg;
        res_next    = res_reg;
        st_next     = st_reg;
        steps_next  = steps_reg;
        hint_next   = hint_reg;
        raw_next    = raw_reg;
        cnt_next    = cnt_reg;
        pend_next   = 1'b0;
        lane_next   = lane_reg;
        phase_next  = phase_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        ores_next   = ores_reg;
        ost_next    = ost_reg;
        mem_cmd     = '0;
        mem_addr    = base + AW'(cnt_reg);
        mem_wdata   = wbytes[{cnt_reg[1:0], 3'b000} +: 8];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = in_ch.action;
                    cl_next    = {14'd0, in_ch.cluster};
                    lv_next    = in_ch.link_value;
                    res_next   = '0;
                    st_next    = fce_pkg::ST_OK;
                    steps_next = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cnt_next = '0;
                raw_next = '0;
                unique case (act_reg)
                    fce_pkg::ACT_READ:
                    begin
                        if (cl_rng)
                            state_next = S_RD;
                        else
                        begin
                            st_next    = fce_pkg::ST_RANGE;
                            state_next = S_DONE;
                        end
                    end
                    fce_pkg::ACT_SET:
                    begin
                        wval_next = lv_reg;
                        if (!cl_rng)
                        begin
                            st_next    = fce_pkg::ST_RANGE;
                            state_next = S_DONE;
                        end
                        else if (fat_kind == fce_pkg::KIND_FAT12)
                            state_next = S_RD;
                        else
                            state_next = S_WR;
                    end
                    fce_pkg::ACT_FIND:
                    begin
                        hint_next  = hint_rng ? hint_reg : fce_pkg::HINT_RESET;
                        cl_next    = hint_rng ? {14'd0, hint_reg} : {14'd0, fce_pkg::HINT_RESET};
                        phase_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    fce_pkg::ACT_FREE:
                        state_next = S_WALK;
                    fce_pkg::ACT_END:
                    begin
                        if (cl_rng)
                            state_next = S_RD;
                        else
                        begin
                            st_next    = fce_pkg::ST_RANGE;
                            state_next = S_DONE;
                        end
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_RD:
            begin
                if (cnt_reg < nb)
                begin
                    mem_cmd.rd = 1'b1;
                    cnt_next   = cnt_reg + 3'd1;
                    pend_next  = 1'b1;
                    lane_next  = cnt_reg[1:0];
                end
                if (pend_reg)
                    raw_next[{lane_reg, 3'b000} +: 8] = mem_rdata;
                if (cnt_reg == nb && pend_reg)
                    state_next = S_POST;
            end
            S_POST:
            begin
                cnt_next = '0;
                unique case (act_reg)
                    fce_pkg::ACT_READ:
                    begin
                        res_next   = link;
                        state_next = S_DONE;
                    end
                    fce_pkg::ACT_SET:
                        state_next = S_WR;
                    fce_pkg::ACT_FIND:
                    begin
                        if (link == 28'd0)
                        begin
                            hint_next  = cl_reg[13:0];
                            res_next   = cl_reg;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cl_next    = cl_reg + 28'd1;
                            state_next = S_SCAN;
                        end
                    end
                    fce_pkg::ACT_FREE:
                    begin
                        nx_next    = link;
                        wval_next  = '0;
                        state_next = S_WR;
                    end
                    fce_pkg::ACT_END:
                    begin
                        nx_next    = link;
                        wval_next  = end_v;
                        state_next = S_WR;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_WR:
            begin
                mem_cmd.wr = 1'b1;
                if (cnt_reg == 3'd0 && wval_reg == 28'd0)
                    hint_next = cl_reg[13:0];
                if (cnt_reg == nb - 3'd1)
                    state_next = S_AFTER;
                else
                    cnt_next = cnt_reg + 3'd1;
            end
            S_AFTER:
            begin
                if (act_reg == fce_pkg::ACT_SET || nx_reg == 28'd0)
                    state_next = S_DONE;
                else if (nx_reg < 28'd2)
                begin
                    st_next    = fce_pkg::ST_BROKEN;
                    state_next = S_DONE;
                end
                else
                begin
                    cl_next    = nx_reg;
                    act_next   = fce_pkg::ACT_FREE;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cnt_next = '0;
                raw_next = '0;
                if (cl_reg >= end_v)
                    state_next = S_DONE;
                else if (!cl_rng)
                begin
                    st_next    = fce_pkg::ST_RANGE;
                    state_next = S_DONE;
                end
                else if (steps_reg >= cluster_count)
                begin
                    st_next    = fce_pkg::ST_BROKEN;
                    state_next = S_DONE;
                end
                else
                begin
                    steps_next = steps_reg + 14'd1;
                    state_next = S_RD;
                end
            end
            S_SCAN:
            begin
                cnt_next = '0;
                raw_next = '0;
                if (!phase_reg && cl_reg > {13'd0, count_p1})
                begin
                    phase_next = 1'b1;
                    cl_next    = 28'd2;
                end
                else if (phase_reg && cl_reg >= {14'd0, hint_reg})
                begin
                    st_next    = fce_pkg::ST_NOFREE;
                    state_next = S_DONE;
                end
                else if (cl_rng)
                    state_next = S_RD;
                else
                    cl_next = cl_reg + 28'd1;
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = (st_reg == fce_pkg::ST_OK) ? res_reg : 28'd0;
                    ost_next    = st_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hint_reg   <= fce_pkg::HINT_RESET;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hint_reg   <= hint_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        cl_reg    <= cl_next;
        lv_reg    <= lv_next;
        nx_reg    <= nx_next;
        wval_reg  <= wval_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
        steps_reg <= steps_next;
        raw_reg   <= raw_next;
        cnt_reg   <= cnt_next;
        lane_reg  <= lane_next;
        phase_reg <= phase_next;
        ores_reg  <= ores_next;
        ost_reg   <= ost_next;
    end

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.result_value = ores_reg;
    assign out_ch.status       = ost_reg;

endmodule

### src/fat_cluster_chain_engine_top.sv
// one transaction in flight; the table memory has a single byte port
// after reset the table is zeroed one byte a cycle, with ready held low
// configuration resets to fat32 with 16382 clusters; free hint resets to cluster 2
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_top
// fat12/16/32 allocation table engine: read, set, find free, free and end chains
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_top #(
    parameter int MAX_CLUSTERS = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    fce_in_if.sink      in_ch,
    fce_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data
);

    // byte address width of the table, four bytes per cluster
    localparam int AW = $clog2(MAX_CLUSTERS) + 2;

    logic [1:0]            kind_reg;
    logic [13:0]           count_reg;
    fce_pkg::fce_mem_cmd_t mem_cmd;
    logic [AW-1:0]         mem_addr;
    logic [7:0]            mem_wdata;
    logic [7:0]            mem_rdata;
    logic                  store_busy;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= fce_pkg::KIND_RESET;
            count_reg <= fce_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fce_pkg::CFG_FAT_KIND)
                kind_reg <= cfg_data[1:0];
            else
                count_reg <= cfg_data;
        end
    end

    // table bytes, cleared by a pass after reset
    fce_store #(
        .AW (AW)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .busy  (store_busy)
    );

    // per-transaction sequencer with output register
    fce_seq #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .AW           (AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fat_kind      (kind_reg),
        .cluster_count (count_reg),
        .store_busy    (store_busy),
        .mem_cmd       (mem_cmd),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata)
    );

    // no transaction taken while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> !in_ch.ready)
        else $error("input ready during table clear");

    // an error result never carries a value
    a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != fce_pkg::ST_OK) |-> out_ch.result_value == 28'd0)
        else $error("error result with nonzero value");

    // table memory never driven while clearing
    a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        store_busy |-> (!mem_cmd.rd && !mem_cmd.wr))
        else $error("memory access during table clear");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the fat chain engine against a local model of the allocation table:
// directed cases per table format, back-pressure and randomized chain traffic
// ----------------------------------------------------------------------------
module testbench;

    // no transaction on either channel for this many cycles ends the run:
    // covers the post-reset table clear and the longest scan or chain walk
    localparam int WATCHDOG_LIMIT = 800000;

    typedef struct {
        logic [27:0] value;
        logic [1:0]  status;
    } link_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic        cfg_we;
    logic        cfg_index;
    logic [13:0] cfg_data;

    fce_in_if  req_ch ();
    fce_out_if rsp_ch ();

    fat_cluster_chain_engine_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (req_ch.sink),
        .out_ch    (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // local model of the table: byte store, free hint and registers
    // ------------------------------------------------------------------
    logic [7:0]   fat_mem [0:65535];
    logic [13:0]  hint_q;
    logic [1:0]   kind_q;
    logic [13:0]  count_q;
    link_result_t pending_results [$];

    int  error_count = 0;
    int  idle_cycles = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    int  rx_hold_req = 0;
    int  rx_wait = 0;

    function automatic int unsigned mem_rd16(int unsigned a);
        int unsigned lo, hi;
        lo = (a < 65536) ? 32'(fat_mem[a]) : 32'd0;
        hi = (a + 1 < 65536) ? 32'(fat_mem[a + 1]) : 32'd0;
        return lo | (hi << 8);
    endfunction

    function automatic void mem_wr16(int unsigned a, int unsigned v);
        if (a < 65536)
            fat_mem[a] = v[7:0];
        if (a + 1 < 65536)
            fat_mem[a + 1] = v[15:8];
    endfunction

    function automatic int unsigned chain_end_mark();
        if (kind_q == fce_pkg::KIND_FAT12)
            return 32'h0000FF8;
        else if (kind_q == fce_pkg::KIND_FAT16)
            return 32'h000FFF8;
        return 32'h0FFFFFF8;
    endfunction

    function automatic bit cluster_ok(int unsigned c);
        if (c < 2 || c > count_q + 1 || c >= 16384)
            return 1'b0;
        if (kind_q == fce_pkg::KIND_FAT12 && c >= 32'hFF8)
            return 1'b0;
        if (kind_q == fce_pkg::KIND_FAT16 && c >= 32'hFFF8)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned link_at(int unsigned c);
        int unsigned v;
        if (kind_q == fce_pkg::KIND_FAT12)
        begin
            v = mem_rd16(c * 3 / 2);
            v = c[0] ? (v >> 4) : (v & 32'h0FFF);
        end
        else if (kind_q == fce_pkg::KIND_FAT16)
            v = mem_rd16(c * 2);
        else
            v = (mem_rd16(c * 4) | (mem_rd16(c * 4 + 2) << 16)) & 32'h0FFFFFFF;
        // reserved end-of-chain range reads back with the low nibble clear
        if (v > chain_end_mark())
            v = v & ~32'hF;
        return v;
    endfunction

    function automatic void link_put(int unsigned c, int unsigned v);
        int unsigned a, old;
        v = v & 32'h0FFFFFFF;
        if (v == 0)
            hint_q = c[13:0];
        if (kind_q == fce_pkg::KIND_FAT12)
        begin
            a = c * 3 / 2;
            old = mem_rd16(a);
            if (c[0])
                old = (old & 32'h000F) | ((v << 4) & 32'hFFF0);
            else
                old = (old & 32'hF000) | (v & 32'h0FFF);
            mem_wr16(a, old);
        end
        else if (kind_q == fce_pkg::KIND_FAT16)
            mem_wr16(c * 2, v);
        else
        begin
            mem_wr16(c * 4, v);
            mem_wr16(c * 4 + 2, v >> 16);
        end
    endfunction

    function automatic logic [1:0] release_chain(int unsigned start);
        int unsigned cl, nx, steps;
        cl = start;
        steps = 0;
        forever
        begin
            if (cl >= chain_end_mark())
                return fce_pkg::ST_OK;
            if (!cluster_ok(cl))
                return fce_pkg::ST_RANGE;
            if (steps >= count_q)
                return fce_pkg::ST_BROKEN;
            steps++;
            nx = link_at(cl);
            link_put(cl, 0);
            if (nx == 0)
                return fce_pkg::ST_OK;
            if (nx < 2)
                return fce_pkg::ST_BROKEN;
            cl = nx;
        end
    endfunction

    function automatic link_result_t table_op(logic [2:0] act, logic [13:0] cl,
                                               logic [27:0] lv);
        link_result_t r;
        int unsigned  k, nx;
        bit           found;
        r.value = '0;
        r.status = fce_pkg::ST_OK;
        found = 1'b0;
        case (act)
            fce_pkg::ACT_READ:
                if (cluster_ok(cl))
                    r.value = 28'(link_at(cl));
                else
                    r.status = fce_pkg::ST_RANGE;
            fce_pkg::ACT_SET:
                if (cluster_ok(cl))
                    link_put(cl, lv);
                else
                    r.status = fce_pkg::ST_RANGE;
            fce_pkg::ACT_FIND:
            begin
                if (!cluster_ok(hint_q))
                    hint_q = fce_pkg::HINT_RESET;
                // scan from the hint to the top, then wrap to cluster 2
                for (k = hint_q; k <= count_q + 1 && !found; k++)
                    if (cluster_ok(k) && link_at(k) == 0)
                    begin
                        found = 1'b1;
                        r.value = 28'(k);
                    end
                for (k = 2; k < hint_q && !found; k++)
                    if (cluster_ok(k) && link_at(k) == 0)
                    begin
                        found = 1'b1;
                        r.value = 28'(k);
                    end
                if (found)
                    hint_q = r.value[13:0];
                else
                    r.status = fce_pkg::ST_NOFREE;
            end
            fce_pkg::ACT_FREE:
                r.status = release_chain(cl);
            fce_pkg::ACT_END:
                if (!cluster_ok(cl))
                    r.status = fce_pkg::ST_RANGE;
                else
                begin
                    nx = link_at(cl);
                    link_put(cl, chain_end_mark());
                    if (nx == 0)
                        r.status = fce_pkg::ST_OK;
                    else if (nx < 2)
                        r.status = fce_pkg::ST_BROKEN;
                    else
                        r.status = release_chain(nx);
                end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side: one transaction per call, random gap before it
    // ------------------------------------------------------------------
    task automatic send_request(logic [2:0] act, logic [13:0] cl, logic [27:0] lv);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 8) : 0;
        repeat (gap)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.cluster    <= cl;
        req_ch.link_value <= lv;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // accepted at this edge: the engine holds one transaction at a time
        pending_results.push_back(table_op(act, cl, lv));
    endtask

    // sender pauses until every expected result has come
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // register writes only with the engine idle; both writes back to back
    task automatic configure(logic [1:0] kind, logic [13:0] count);
        req_ch.valid <= 1'b0;
        drain_results();
        repeat (16) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= fce_pkg::CFG_FAT_KIND;
        cfg_data  <= {12'd0, kind};
        @(posedge clk);
        kind_q    = kind;
        cfg_index <= fce_pkg::CFG_CLUSTER_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        count_q   = count;
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, long hold on request, compare in order
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected transaction: expected none actual %h/%h",
                             $time, rsp_ch.result_value, rsp_ch.status);
                    error_count++;
                end
                else
                begin
                    link_result_t e;
                    e = pending_results.pop_front();
                    if (rsp_ch.result_value !== e.value)
                    begin
                        $display("%0t result_value mismatch: expected %h actual %h",
                                 $time, e.value, rsp_ch.result_value);
                        error_count++;
                    end
                    if (rsp_ch.status !== e.status)
                    begin
                        $display("%0t status mismatch: expected %h actual %h",
                                 $time, e.status, rsp_ch.status);
                        error_count++;
                    end
                end
                rx_wait = rx_idle_en ? $urandom_range(0, 8) : 0;
            end
            if (rx_hold_req != 0)
            begin
                rx_wait = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("fat_cluster_chain_engine_top test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // random field helpers, mostly inside a small working window
    // ------------------------------------------------------------------
    function automatic logic [13:0] pick_cluster();
        int unsigned top;
        top = (count_q + 2 > 70) ? 70 : count_q + 2;
        if ($urandom_range(0, 99) < 85)
            return 14'($urandom_range(0, top));
        return 14'($urandom_range(0, 16383));
    endfunction

    function automatic logic [27:0] pick_link();
        int unsigned top, sel;
        top = (count_q + 1 > 70) ? 70 : count_q + 1;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 28'($urandom_range(2, (top < 2) ? 2 : top));
        else if (sel < 70)
            return 28'd0;
        else if (sel < 80)
            return 28'(chain_end_mark() + $urandom_range(0, 7));
        else if (sel < 85)
            return 28'd1;
        return 28'($urandom() & 32'h0FFFFFFF);
    endfunction

    task automatic random_items(int n);
        int unsigned sel;
        logic [2:0]  act;
        repeat (n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 35)      act = fce_pkg::ACT_SET;
            else if (sel < 60) act = fce_pkg::ACT_READ;
            else if (sel < 75) act = fce_pkg::ACT_FIND;
            else if (sel < 85) act = fce_pkg::ACT_FREE;
            else if (sel < 95) act = fce_pkg::ACT_END;
            else               act = 3'($urandom_range(5, 7));
            send_request(act, pick_cluster(), pick_link());
        end
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------
    // reset configuration: fat32 over the full cluster range
    task automatic test_fat32_basics();
        send_request(fce_pkg::ACT_READ, 14'd2, 28'd0);
        send_request(fce_pkg::ACT_READ, 14'd0, 28'd0);          // below first data cluster
        send_request(fce_pkg::ACT_SET, 14'd16383, 28'hFFFFFFF); // top cluster, all ones
        send_request(fce_pkg::ACT_READ, 14'd16383, 28'd0);      // end range drops low nibble
        send_request(fce_pkg::ACT_SET, 14'd3, 28'd4);
        send_request(fce_pkg::ACT_SET, 14'd4, 28'd5);
        send_request(fce_pkg::ACT_SET, 14'd5, 28'h0FFFFFF8);
        send_request(fce_pkg::ACT_FREE, 14'd3, 28'd0);          // walk to the end mark
        send_request(fce_pkg::ACT_FIND, 14'd0, 28'd0);
        send_request(fce_pkg::ACT_END, 14'd2, 28'd0);           // old link free
        send_request(fce_pkg::ACT_SET, 14'd6, 28'd1);
        send_request(fce_pkg::ACT_END, 14'd6, 28'd0);           // old link one: broken
        send_request(fce_pkg::ACT_SET, 14'd7, 28'd8);
        send_request(fce_pkg::ACT_SET, 14'd8, 28'd1);
        send_request(fce_pkg::ACT_FREE, 14'd7, 28'd0);          // broken link in the chain
        send_request(3'd7, 14'h3FFF, 28'd0);                    // unused action code
    endtask

    // fat12 packing and format limits, kind 3 read as fat32
    task automatic test_fat12_packing();
        configure(fce_pkg::KIND_FAT12, 14'd16382);
        send_request(fce_pkg::ACT_SET, 14'd2, 28'hABC);
        send_request(fce_pkg::ACT_SET, 14'd3, 28'h123);         // shares a byte with 2
        send_request(fce_pkg::ACT_READ, 14'd2, 28'd0);
        send_request(fce_pkg::ACT_READ, 14'd3, 28'd0);
        send_request(fce_pkg::ACT_READ, 14'd4088, 28'd0);       // at the fat12 end value
        send_request(fce_pkg::ACT_FREE, 14'd4088, 28'd0);       // start at end value
        configure(2'd3, 14'd40);
        send_request(fce_pkg::ACT_SET, 14'd9, 28'hFFFFFFF);
        send_request(fce_pkg::ACT_READ, 14'd9, 28'd0);
    endtask

    // one-cluster volume: the scan finds nothing once cluster 2 is taken
    task automatic test_tiny_volume();
        configure(fce_pkg::KIND_FAT16, 14'd1);
        send_request(fce_pkg::ACT_FIND, 14'd0, 28'd0);
        send_request(fce_pkg::ACT_SET, 14'd2, 28'hFFFF);
        send_request(fce_pkg::ACT_FIND, 14'd0, 28'd0);
        send_request(fce_pkg::ACT_READ, 14'd3, 28'd0);          // just past the last cluster
    endtask

    // long output stall with the sender busy, then a full drain pause
    task automatic test_backpressure();
        configure(fce_pkg::KIND_FAT32, 14'd32);
        tx_idle_en = 1'b0;
        rx_hold_req = 400;
        random_items(12);
        tx_idle_en = 1'b1;
        drain_results();
        random_items(10);
    endtask

    // randomized traffic across formats and sizes, with and without gaps
    task automatic test_random_mix();
        configure(fce_pkg::KIND_FAT12, 14'd24);
        random_items(90);
        configure(fce_pkg::KIND_FAT16, 14'd48);
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        random_items(60);
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        configure(fce_pkg::KIND_FAT32, 14'd16);
        random_items(90);
        configure(fce_pkg::KIND_FAT12, 14'd16382);
        random_items(70);
        configure(fce_pkg::KIND_FAT32, 14'd16382);
        random_items(70);
        configure(fce_pkg::KIND_FAT16, 14'd8);
        random_items(60);
        configure(2'd3, 14'd64);
        random_items(60);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid      <= 1'b0;
        req_ch.action     <= fce_pkg::ACT_READ;
        req_ch.cluster    <= '0;
        req_ch.link_value <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= fce_pkg::CFG_FAT_KIND;
        cfg_data  <= '0;
        foreach (fat_mem[i])
            fat_mem[i] = 8'd0;
        hint_q  = fce_pkg::HINT_RESET;
        kind_q  = fce_pkg::KIND_RESET;
        count_q = fce_pkg::COUNT_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fat32_basics();
        test_fat12_packing();
        test_tiny_volume();
        test_backpressure();
        test_random_mix();

        req_ch.valid <= 1'b0;
        drain_results();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("fat_cluster_chain_engine_top test passed");
        else
            $display("fat_cluster_chain_engine_top test failed");
        $finish;
    end

endmodule
